### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions on a clock with synchronous reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Whenever the trigger holds, the consequence must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst, trig, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error(msg);

`endif

### rtl/bdq_pkg.sv
// ---------------------------------------------------------------------------
// Bounded deque package
// Sizes, command codes and sequencer states of the bounded deque.
// ---------------------------------------------------------------------------
package bdq_pkg;

   localparam int DEPTH   = 16;
   localparam int AW      = $clog2(DEPTH);
   localparam int CW      = $clog2(DEPTH + 1);
   localparam int VALUE_W = 32;
   localparam int CMD_W   = 3;
   localparam int COUNT_W = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_INSERT     = 3'd4,
      CMD_DUMP       = 3'd5
   } cmd_type;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_POPW  = 7'b0000010,
      ST_SCAN  = 7'b0000100,
      ST_SHIFT = 7'b0001000,
      ST_PLACE = 7'b0010000,
      ST_DUMP  = 7'b0100000,
      ST_RESP  = 7'b1000000
   } state_type;

endpackage

### rtl/bdq_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module bdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### rtl/bounded_deque_with_sorted_insert_unit.sv
// ---------------------------------------------------------------------------
// Bounded deque with sorted insert
// Circular list in RAM, walked by a small sequencer and one comparator.
// ---------------------------------------------------------------------------
// One command is worked at a time; req_stall stays high until the last beat
// of the command's results has been taken, so no new command is taken before then.
// The single RAM port pair and the one entry compare per cycle bound each command's length.
// Reset (synchronous) empties the list at once; stored values are not cleared.
`include "assert_macros.svh"

module bounded_deque_with_sorted_insert_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [bdq_pkg::CMD_W-1:0]          req_command,
   input  logic signed [bdq_pkg::VALUE_W-1:0] req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [bdq_pkg::VALUE_W-1:0] rsp_item_value,
   output logic                               rsp_has_item,
   output logic                               rsp_failed,
   output logic [bdq_pkg::COUNT_W-1:0]        rsp_entry_count,
   output logic                               rsp_is_empty,
   output logic                               rsp_last_result
);

   localparam int AW = bdq_pkg::AW;
   localparam int CW = bdq_pkg::CW;
   localparam int VW = bdq_pkg::VALUE_W;

   bdq_pkg::state_type state_ff, state_in;
   bdq_pkg::cmd_type   cmd_ff, cmd_in;
   logic signed [VW-1:0] val_ff, val_in;
   logic [AW-1:0]        head_ff, head_in;
   logic [CW-1:0]        occ_ff, occ_in;
   logic [CW-1:0]        pos_ff, pos_in;
   logic [CW-1:0]        sh_ff, sh_in;
   logic [VW-1:0]        item_ff, item_in;
   logic                 has_ff, has_in;
   logic                 fail_ff, fail_in;
   logic                 last_ff, last_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [VW-1:0] wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [VW-1:0] rd_data;

   logic full;
   logic empty;

   // Maps a list position to its RAM address, relative to the front entry.
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] p);
      logic [CW:0] sum;
      sum = (CW+1)'(h) + (CW+1)'(p);
      if (sum >= (CW+1)'(bdq_pkg::DEPTH)) begin
         sum = sum - (CW+1)'(bdq_pkg::DEPTH);
      end
      return AW'(sum);
   endfunction

   function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] h);
      return (h == '0) ? AW'(bdq_pkg::DEPTH - 1) : h - AW'(1);
   endfunction

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] h);
      return (h == AW'(bdq_pkg::DEPTH - 1)) ? '0 : h + AW'(1);
   endfunction

   assign full  = (occ_ff == CW'(bdq_pkg::DEPTH));
   assign empty = (occ_ff == '0);

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      val_in   = val_ff;
      head_in  = head_ff;
      occ_in   = occ_ff;
      pos_in   = pos_ff;
      sh_in    = sh_ff;
      item_in  = item_ff;
      has_in   = has_ff;
      fail_in  = fail_ff;
      last_in  = last_ff;
      wr_en    = 1'b0;
      wr_addr  = head_ff;
      wr_data  = val_ff;
      rd_en    = 1'b0;
      rd_addr  = head_ff;

      case (state_ff)
         bdq_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = bdq_pkg::cmd_type'(req_command);
               val_in   = req_value;
               item_in  = '0;
               has_in   = 1'b0;
               fail_in  = 1'b0;
               last_in  = 1'b1;
               state_in = bdq_pkg::ST_RESP;
               case (bdq_pkg::cmd_type'(req_command))
                  bdq_pkg::CMD_PUSH_FRONT: begin
                     if (full) begin
                        fail_in = 1'b1;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = wrap_dec(head_ff);
                        wr_data = req_value;
                        head_in = wrap_dec(head_ff);
                        occ_in  = occ_ff + CW'(1);
                     end
                  end
                  bdq_pkg::CMD_PUSH_BACK: begin
                     if (full) begin
                        fail_in = 1'b1;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = phys(head_ff, occ_ff);
                        wr_data = req_value;
                        occ_in  = occ_ff + CW'(1);
                     end
                  end
                  bdq_pkg::CMD_POP_FRONT, bdq_pkg::CMD_POP_BACK: begin
                     if (empty) begin
                        fail_in = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = (bdq_pkg::cmd_type'(req_command) == bdq_pkg::CMD_POP_FRONT)
                                   ? head_ff : phys(head_ff, occ_ff - CW'(1));
                        state_in = bdq_pkg::ST_POPW;
                     end
                  end
                  bdq_pkg::CMD_INSERT: begin
                     if (full) begin
                        fail_in = 1'b1;
                     end else if (empty) begin
                        wr_en   = 1'b1;
                        wr_addr = head_ff;
                        wr_data = req_value;
                        occ_in  = occ_ff + CW'(1);
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        pos_in   = '0;
                        state_in = bdq_pkg::ST_SCAN;
                     end
                  end
                  bdq_pkg::CMD_DUMP: begin
                     if (!empty) begin
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        pos_in   = '0;
                        state_in = bdq_pkg::ST_DUMP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         bdq_pkg::ST_POPW: begin
            item_in  = rd_data;
            has_in   = 1'b1;
            occ_in   = occ_ff - CW'(1);
            if (cmd_ff == bdq_pkg::CMD_POP_FRONT) begin
               head_in = wrap_inc(head_ff);
            end
            state_in = bdq_pkg::ST_RESP;
         end

         bdq_pkg::ST_SCAN: begin
            // Equal values walk past, so the new entry lands behind its equals.
            if (val_ff >= $signed(rd_data)) begin
               if (pos_ff + CW'(1) == occ_ff) begin
                  wr_en    = 1'b1;
                  wr_addr  = phys(head_ff, occ_ff);
                  occ_in   = occ_ff + CW'(1);
                  state_in = bdq_pkg::ST_RESP;
               end else begin
                  pos_in  = pos_ff + CW'(1);
                  rd_en   = 1'b1;
                  rd_addr = phys(head_ff, pos_ff + CW'(1));
               end
            end else begin
               rd_en    = 1'b1;
               rd_addr  = phys(head_ff, occ_ff - CW'(1));
               sh_in    = occ_ff;
               state_in = bdq_pkg::ST_SHIFT;
            end
         end

         bdq_pkg::ST_SHIFT: begin
            // Read two slots below the write so each cycle moves one entry back.
            wr_en   = 1'b1;
            wr_addr = phys(head_ff, sh_ff);
            wr_data = rd_data;
            if (sh_ff == pos_ff + CW'(1)) begin
               state_in = bdq_pkg::ST_PLACE;
            end else begin
               sh_in   = sh_ff - CW'(1);
               rd_en   = 1'b1;
               rd_addr = phys(head_ff, sh_ff - CW'(2));
            end
         end

         bdq_pkg::ST_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = phys(head_ff, pos_ff);
            occ_in   = occ_ff + CW'(1);
            state_in = bdq_pkg::ST_RESP;
         end

         bdq_pkg::ST_DUMP: begin
            item_in  = rd_data;
            has_in   = 1'b1;
            last_in  = (pos_ff + CW'(1) == occ_ff);
            state_in = bdq_pkg::ST_RESP;
         end

         bdq_pkg::ST_RESP: begin
            if (!rsp_stall) begin
               if (cmd_ff == bdq_pkg::CMD_DUMP && !last_ff) begin
                  pos_in   = pos_ff + CW'(1);
                  rd_en    = 1'b1;
                  rd_addr  = phys(head_ff, pos_ff + CW'(1));
                  state_in = bdq_pkg::ST_DUMP;
               end else begin
                  state_in = bdq_pkg::ST_IDLE;
               end
            end
         end

         default: begin
            state_in = bdq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bdq_pkg::ST_IDLE;
         head_ff  <= '0;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         occ_ff   <= occ_in;
      end
      cmd_ff  <= cmd_in;
      val_ff  <= val_in;
      pos_ff  <= pos_in;
      sh_ff   <= sh_in;
      item_ff <= item_in;
      has_ff  <= has_in;
      fail_ff <= fail_in;
      last_ff <= last_in;
   end

   bdq_ram #(
      .WIDTH(VW),
      .DEPTH(bdq_pkg::DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign req_stall       = (state_ff != bdq_pkg::ST_IDLE);
   assign rsp_valid       = (state_ff == bdq_pkg::ST_RESP);
   assign rsp_item_value  = $signed(item_ff);
   assign rsp_has_item    = has_ff;
   assign rsp_failed      = fail_ff;
   assign rsp_entry_count = bdq_pkg::COUNT_W'(occ_ff);
   assign rsp_is_empty    = empty;
   assign rsp_last_result = last_ff;

   `ASSERT_ALWAYS(a_occ_in_range, clock, reset,
                  occ_ff <= CW'(bdq_pkg::DEPTH), "occupancy exceeds depth")
   `ASSERT_ALWAYS(a_shift_above_slot, clock, reset,
                  (state_ff != bdq_pkg::ST_SHIFT) || (sh_ff > pos_ff),
                  "shift passed the insert slot")
   `ASSERT_NEXT(a_stalled_state_holds, clock, reset, rsp_valid && rsp_stall,
                $stable(occ_ff) && $stable(head_ff), "list changed under a stalled beat")

endmodule
